[src/stpb_pkg.sv]
// Shared types and constants for the spectrum peak-bin picker.
// Used by stpb_front, stpb_queue, stpb_back and spectrum_top_peak_bins.
`default_nettype none

package stpb_pkg;

    localparam int DEF_MAX_BINS    = 4096;
    localparam int DEF_MAX_TARGETS = 16;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam int TARGET_W  = 5;
    localparam int COUNT_W   = 12;
    localparam int OUT_BIN_W = 12;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 5'd1;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 12'd4095;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_NONE = 2'd1,
        STATUS_FEW  = 2'd2
    } stpb_status_t;

    typedef struct packed {
        logic is_peak;
        logic last;
    } stpb_flags_t;

endpackage

`default_nettype wire

[src/spectrum_top_peak_bins.sv]
// Top level of the streaming top-k spectral peak picker.
// Instantiates stpb_front, stpb_queue and stpb_back; uses stpb_pkg.
//
// channel   | handshake                    | payload
// ----------+------------------------------+------------------------------------------
// sample    | sample_valid / sample_ready  | magnitude, last_sample
// result    | result_valid / result_ready  | bin_index, status, peak_count, last_result
// config    | cfg_wr_en (no wait)          | cfg_wr_data -> target_count
//
// Ordinary items are taken one per cycle while the queue has room; the back end
// inserts one item per cycle in BK_RUN through a parallel compare-and-shift table.
// After a last item the back end ranks the table in BK_RANK, then sends 1 to
// MAX_TARGETS results in BK_SEND; the four-entry queue takes items while not full.
// Reset clears the window, counters, queue and table fill; no clearing pass.
// Either side may stall at any time; the queue and the output register hold.
`default_nettype none

module spectrum_top_peak_bins #(
    parameter int MAX_BINS    = stpb_pkg::DEF_MAX_BINS,
    parameter int MAX_TARGETS = stpb_pkg::DEF_MAX_TARGETS,
    parameter int SAMPLE_BITS = stpb_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    output logic                               sample_ready,
    input  wire logic [SAMPLE_BITS-1:0]        magnitude,
    input  wire logic                          last_sample,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic [stpb_pkg::OUT_BIN_W-1:0]     bin_index,
    output logic [1:0]                         status,
    output logic [stpb_pkg::COUNT_W-1:0]       peak_count,
    output logic                               last_result,
    input  wire logic                          cfg_wr_en,
    input  wire logic [stpb_pkg::TARGET_W-1:0] cfg_wr_data
);

    localparam int BIN_W = $clog2(MAX_BINS);
    localparam int QW    = 2 + SAMPLE_BITS + BIN_W;

    logic [stpb_pkg::TARGET_W-1:0] target_reg, target_next;

    logic                   push_valid;
    logic                   push_ready;
    stpb_pkg::stpb_flags_t  push_flags;
    logic [SAMPLE_BITS-1:0] push_mag;
    logic [BIN_W-1:0]       push_bin;
    logic [QW-1:0]          q_wr;
    logic [QW-1:0]          q_rd;
    logic                   q_valid;
    logic                   q_ready;
    stpb_pkg::stpb_flags_t  q_flags;

    assign target_next = cfg_wr_en ? cfg_wr_data : target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= stpb_pkg::TARGET_RESET;
        end
        else
        begin
            target_reg <= target_next;
        end
    end

    stpb_front #(
        .MAX_BINS    (MAX_BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .magnitude    (magnitude),
        .last_sample  (last_sample),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_flags   (push_flags),
        .push_mag     (push_mag),
        .push_bin     (push_bin)
    );

    assign q_wr = {push_flags, push_mag, push_bin};

    stpb_queue #(
        .WIDTH (QW),
        .DEPTH (stpb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (q_wr),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_rd)
    );

    assign q_flags = stpb_pkg::stpb_flags_t'(q_rd[QW-1 -: 2]);

    stpb_back #(
        .MAX_BINS    (MAX_BINS),
        .MAX_TARGETS (MAX_TARGETS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_flags      (q_flags),
        .q_mag        (q_rd[BIN_W +: SAMPLE_BITS]),
        .q_bin        (q_rd[BIN_W-1:0]),
        .target_count (target_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .bin_index    (bin_index),
        .status       (status),
        .peak_count   (peak_count),
        .last_result  (last_result)
    );

    a_bin_zero_unless_ok : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (status == stpb_pkg::STATUS_OK) || (bin_index == '0))
        else $error("bin_index not zero on a status-only result");

    a_none_is_final : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == stpb_pkg::STATUS_NONE) |-> last_result && (peak_count == '0))
        else $error("no-peak result must be final with zero count");

    a_few_is_final : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == stpb_pkg::STATUS_FEW) |-> last_result && (peak_count != '0))
        else $error("too-few result must be final with nonzero count");

    a_ok_burst_continues : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && (status == stpb_pkg::STATUS_OK) && !last_result
        |=> result_valid)
        else $error("gap inside a burst of selected bins");

endmodule

`default_nettype wire

[src/stpb_front.sv]
// Front end: three-sample window, bin counter and peak classification.
// Depends on stpb_pkg for the flag struct and parameter defaults.
`default_nettype none

module stpb_front #(
    parameter int MAX_BINS    = stpb_pkg::DEF_MAX_BINS,
    parameter int SAMPLE_BITS = stpb_pkg::DEF_SAMPLE_BITS,
    localparam int BIN_W      = $clog2(MAX_BINS)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_valid,
    output logic                        sample_ready,
    input  wire logic [SAMPLE_BITS-1:0] magnitude,
    input  wire logic                   last_sample,
    output logic                        push_valid,
    input  wire logic                   push_ready,
    output stpb_pkg::stpb_flags_t       push_flags,
    output logic [SAMPLE_BITS-1:0]      push_mag,
    output logic [BIN_W-1:0]            push_bin
);

    logic [SAMPLE_BITS-1:0] older_reg, older_next;
    logic [SAMPLE_BITS-1:0] newer_reg, newer_next;
    logic [BIN_W-1:0]       bin_cnt_reg, bin_cnt_next;
    logic                   push;

    assign sample_ready = push_ready;
    assign push_valid   = sample_valid;
    assign push         = sample_valid && push_ready;

    assign push_flags.is_peak = (bin_cnt_reg >= BIN_W'(2)) && (newer_reg > older_reg)
                                && (newer_reg > magnitude);
    assign push_flags.last    = last_sample;
    assign push_mag           = newer_reg;
    assign push_bin           = bin_cnt_reg - BIN_W'(1);

    always_comb
    begin
        older_next   = older_reg;
        newer_next   = newer_reg;
        bin_cnt_next = bin_cnt_reg;
        if (push)
        begin
            if (last_sample)
            begin
                older_next   = '0;
                newer_next   = '0;
                bin_cnt_next = '0;
            end
            else
            begin
                older_next = newer_reg;
                newer_next = magnitude;
                if (bin_cnt_reg < BIN_W'(MAX_BINS - 1))
                begin
                    bin_cnt_next = bin_cnt_reg + BIN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg   <= '0;
            newer_reg   <= '0;
            bin_cnt_reg <= '0;
        end
        else
        begin
            older_reg   <= older_next;
            newer_reg   <= newer_next;
            bin_cnt_reg <= bin_cnt_next;
        end
    end

endmodule

`default_nettype wire

[src/stpb_queue.sv]
// Short register FIFO that decouples the front end from the back end.
// Depends on stpb_pkg for the default depth.
`default_nettype none

module stpb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = stpb_pkg::QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = cnt_reg != CNT_W'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = slot_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[src/stpb_back.sv]
// Back end: sorted top-k table with parallel insertion, bin ranking and report.
// Depends on stpb_pkg for status codes, flags and count constants.
`default_nettype none

module stpb_back #(
    parameter int MAX_BINS    = stpb_pkg::DEF_MAX_BINS,
    parameter int MAX_TARGETS = stpb_pkg::DEF_MAX_TARGETS,
    parameter int SAMPLE_BITS = stpb_pkg::DEF_SAMPLE_BITS,
    localparam int BIN_W      = $clog2(MAX_BINS),
    localparam int TGT_W      = $clog2(MAX_TARGETS + 1),
    localparam int EXT_W      = (BIN_W > stpb_pkg::OUT_BIN_W) ? BIN_W : stpb_pkg::OUT_BIN_W
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_valid,
    output logic                                 q_ready,
    input  wire stpb_pkg::stpb_flags_t           q_flags,
    input  wire logic [SAMPLE_BITS-1:0]          q_mag,
    input  wire logic [BIN_W-1:0]                q_bin,
    input  wire logic [stpb_pkg::TARGET_W-1:0]   target_count,
    output logic                                 result_valid,
    input  wire logic                            result_ready,
    output logic [stpb_pkg::OUT_BIN_W-1:0]       bin_index,
    output logic [1:0]                           status,
    output logic [stpb_pkg::COUNT_W-1:0]         peak_count,
    output logic                                 last_result
);

    typedef enum logic [2:0] {
        BK_RUN  = 3'b001,
        BK_RANK = 3'b010,
        BK_SEND = 3'b100
    } bk_state_t;

    bk_state_t                      state_reg, state_next;
    logic [TGT_W-1:0]               fill_reg, fill_next;
    logic [stpb_pkg::COUNT_W-1:0]   found_reg, found_next;
    logic [TGT_W-1:0]               idx_reg, idx_next;
    logic                           out_valid_reg, out_valid_next;

    logic [SAMPLE_BITS-1:0]         mag_reg [MAX_TARGETS];
    logic [SAMPLE_BITS-1:0]         mag_next [MAX_TARGETS];
    logic [BIN_W-1:0]               tbin_reg [MAX_TARGETS];
    logic [BIN_W-1:0]               tbin_next [MAX_TARGETS];
    logic [TGT_W-1:0]               rank_reg [MAX_TARGETS];
    logic [TGT_W-1:0]               rank_next [MAX_TARGETS];
    logic [TGT_W-1:0]               m_reg, m_next;
    logic [stpb_pkg::COUNT_W-1:0]   count_reg, count_next;
    stpb_pkg::stpb_status_t         mode_reg, mode_next;

    logic [stpb_pkg::OUT_BIN_W-1:0] obin_reg, obin_next;
    stpb_pkg::stpb_status_t         ostat_reg, ostat_next;
    logic [stpb_pkg::COUNT_W-1:0]   ocount_reg, ocount_next;
    logic                           olast_reg, olast_next;

    logic [TGT_W-1:0]               k;
    logic [TGT_W-1:0]               fill_m;
    logic [MAX_TARGETS-1:0]         ge;
    logic [TGT_W-1:0]               pos;
    logic                           drop;
    logic [TGT_W-1:0]               new_fill;
    logic [SAMPLE_BITS-1:0]         mag_ins [MAX_TARGETS];
    logic [BIN_W-1:0]               bin_ins [MAX_TARGETS];
    logic [TGT_W-1:0]               rank_calc [MAX_TARGETS];
    logic [BIN_W-1:0]               sel_bin;
    logic [EXT_W-1:0]               sel_ext;

    always_comb
    begin
        if (target_count == '0)
        begin
            k = TGT_W'(1);
        end
        else if (32'(target_count) > MAX_TARGETS)
        begin
            k = TGT_W'(MAX_TARGETS);
        end
        else
        begin
            k = TGT_W'(target_count);
        end
    end

    assign fill_m = (fill_reg < k) ? fill_reg : k;

    always_comb
    begin
        logic prev;
        for (int i = 0; i < MAX_TARGETS; i++)
        begin
            ge[i] = (i < int'(fill_m)) && (mag_reg[i] >= q_mag);
        end
        pos      = TGT_W'($countones(ge));
        drop     = pos >= k;
        new_fill = (fill_m < k) ? fill_m + TGT_W'(1) : k;
        for (int i = 0; i < MAX_TARGETS; i++)
        begin
            prev = (i == 0) ? 1'b1 : ge[(i == 0) ? 0 : i - 1];
            if (ge[i])
            begin
                mag_ins[i] = mag_reg[i];
                bin_ins[i] = tbin_reg[i];
            end
            else if (prev)
            begin
                mag_ins[i] = q_mag;
                bin_ins[i] = q_bin;
            end
            else
            begin
                mag_ins[i] = mag_reg[(i == 0) ? 0 : i - 1];
                bin_ins[i] = tbin_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_comb
    begin
        logic [MAX_TARGETS-1:0] cmp;
        for (int i = 0; i < MAX_TARGETS; i++)
        begin
            for (int j = 0; j < MAX_TARGETS; j++)
            begin
                cmp[j] = (j < int'(fill_m))
                         && ((tbin_reg[j] < tbin_reg[i])
                             || ((tbin_reg[j] == tbin_reg[i]) && (j < i)));
            end
            rank_calc[i] = TGT_W'($countones(cmp));
        end
    end

    always_comb
    begin
        sel_bin = '0;
        for (int i = 0; i < MAX_TARGETS; i++)
        begin
            if ((i < int'(m_reg)) && (rank_reg[i] == idx_reg))
            begin
                sel_bin = tbin_reg[i];
            end
        end
    end

    assign sel_ext = EXT_W'(sel_bin);
    assign q_ready = state_reg == BK_RUN;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        mag_next       = mag_reg;
        tbin_next      = tbin_reg;
        rank_next      = rank_reg;
        m_next         = m_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        obin_next      = obin_reg;
        ostat_next     = ostat_reg;
        ocount_next    = ocount_reg;
        olast_next     = olast_reg;

        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_RUN:
            begin
                if (q_valid)
                begin
                    if (q_flags.is_peak)
                    begin
                        if (found_reg < stpb_pkg::COUNT_MAX)
                        begin
                            found_next = found_reg + stpb_pkg::COUNT_W'(1);
                        end
                        if (drop)
                        begin
                            fill_next = fill_m;
                        end
                        else
                        begin
                            fill_next = new_fill;
                            mag_next  = mag_ins;
                            tbin_next = bin_ins;
                        end
                    end
                    if (q_flags.last)
                    begin
                        state_next = BK_RANK;
                    end
                end
            end
            BK_RANK:
            begin
                count_next = found_reg;
                m_next     = fill_m;
                rank_next  = rank_calc;
                idx_next   = '0;
                if (found_reg == '0)
                begin
                    mode_next = stpb_pkg::STATUS_NONE;
                end
                else if (found_reg <= stpb_pkg::COUNT_W'(k))
                begin
                    mode_next = stpb_pkg::STATUS_FEW;
                end
                else
                begin
                    mode_next = stpb_pkg::STATUS_OK;
                end
                found_next = '0;
                fill_next  = '0;
                state_next = BK_SEND;
            end
            BK_SEND:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next = 1'b1;
                    ostat_next     = mode_reg;
                    ocount_next    = count_reg;
                    if (mode_reg != stpb_pkg::STATUS_OK)
                    begin
                        obin_next  = '0;
                        olast_next = 1'b1;
                        state_next = BK_RUN;
                    end
                    else
                    begin
                        obin_next  = sel_ext[stpb_pkg::OUT_BIN_W-1:0];
                        olast_next = idx_reg == m_reg - TGT_W'(1);
                        idx_next   = idx_reg + TGT_W'(1);
                        if (idx_reg == m_reg - TGT_W'(1))
                        begin
                            state_next = BK_RUN;
                        end
                    end
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            fill_reg      <= '0;
            found_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        tbin_reg   <= tbin_next;
        rank_reg   <= rank_next;
        m_reg      <= m_next;
        count_reg  <= count_next;
        mode_reg   <= mode_next;
        obin_reg   <= obin_next;
        ostat_reg  <= ostat_next;
        ocount_reg <= ocount_next;
        olast_reg  <= olast_next;
    end

    assign result_valid = out_valid_reg;
    assign bin_index    = obin_reg;
    assign status       = ostat_reg;
    assign peak_count   = ocount_reg;
    assign last_result  = olast_reg;

endmodule

`default_nettype wire

[test/testbench.sv]
// Testbench for spectrum_top_peak_bins: directed, random and backpressure runs,
// each result checked field by field against an in-bench prediction of the peak table.
// Depends on stpb_pkg and the spectrum_top_peak_bins RTL.
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic [stpb_pkg::OUT_BIN_W-1:0] bin;
        stpb_pkg::stpb_status_t         status;
        logic [stpb_pkg::COUNT_W-1:0]   count;
        logic                           is_last;
    } peak_report_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 sample_valid;
    logic                                 sample_ready;
    logic [stpb_pkg::DEF_SAMPLE_BITS-1:0] magnitude;
    logic                                 last_sample;
    logic                                 result_valid;
    logic                                 result_ready;
    logic [stpb_pkg::OUT_BIN_W-1:0]       bin_index;
    logic [1:0]                           status;
    logic [stpb_pkg::COUNT_W-1:0]         peak_count;
    logic                                 last_result;
    logic                                 cfg_wr_en;
    logic [stpb_pkg::TARGET_W-1:0]        cfg_wr_data;

    spectrum_top_peak_bins u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .magnitude    (magnitude),
        .last_sample  (last_sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .bin_index    (bin_index),
        .status       (status),
        .peak_count   (peak_count),
        .last_result  (last_result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    logic [stpb_pkg::TARGET_W-1:0]        target_reg;
    logic [stpb_pkg::DEF_SAMPLE_BITS-1:0] win_older;
    logic [stpb_pkg::DEF_SAMPLE_BITS-1:0] win_newer;
    logic [stpb_pkg::COUNT_W-1:0]         bin_count;
    logic [stpb_pkg::COUNT_W-1:0]         peaks_found;
    logic [stpb_pkg::TARGET_W-1:0]        table_fill;
    logic [stpb_pkg::DEF_SAMPLE_BITS-1:0] top_mag [stpb_pkg::DEF_MAX_TARGETS];
    logic [stpb_pkg::OUT_BIN_W-1:0]       top_bin [stpb_pkg::DEF_MAX_TARGETS];

    peak_report_t expected_reports[$];
    peak_report_t oldest_report;
    int           spectrum_buf[$];

    int  mismatches;
    int  items_sent;
    int  spectra_sent;
    int  reports_checked;
    int  burst_left;
    bit  hold_request;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("timeout with %0d results outstanding", expected_reports.size());
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic predict_sample(input logic [stpb_pkg::DEF_SAMPLE_BITS-1:0] mag,
                                  input logic is_last);
        int           k;
        int           fill;
        int           pos;
        int           i;
        int           j;
        int           m;
        int           sorted_bins[stpb_pkg::DEF_MAX_TARGETS];
        peak_report_t rep;
        k = (target_reg < 1) ? 1 : (target_reg > stpb_pkg::DEF_MAX_TARGETS)
                                   ? stpb_pkg::DEF_MAX_TARGETS : int'(target_reg);
        if (bin_count >= 2 && win_newer > win_older && win_newer > mag)
        begin
            if (peaks_found < stpb_pkg::COUNT_MAX)
                peaks_found++;
            fill = (table_fill < k) ? int'(table_fill) : k;
            pos = 0;
            while (pos < fill && top_mag[pos] >= win_newer)
                pos++;
            if (pos >= k)
                table_fill = fill;
            else
            begin
                i = (fill < k) ? fill : k - 1;
                while (i > pos)
                begin
                    top_mag[i] = top_mag[i-1];
                    top_bin[i] = top_bin[i-1];
                    i--;
                end
                top_mag[pos] = win_newer;
                top_bin[pos] = bin_count - 1'b1;
                table_fill = (fill < k) ? fill + 1 : k;
            end
        end
        win_older = win_newer;
        win_newer = mag;
        if (bin_count < stpb_pkg::DEF_MAX_BINS - 1)
            bin_count++;
        if (!is_last)
            return;
        rep.bin = '0;
        rep.count = peaks_found;
        rep.is_last = 1'b1;
        if (peaks_found == 0)
        begin
            rep.status = stpb_pkg::STATUS_NONE;
            expected_reports.push_back(rep);
        end
        else if (peaks_found <= k)
        begin
            rep.status = stpb_pkg::STATUS_FEW;
            expected_reports.push_back(rep);
        end
        else
        begin
            m = (table_fill < k) ? int'(table_fill) : k;
            for (i = 0; i < m; i++)
            begin
                j = i;
                while (j > 0 && sorted_bins[j-1] > int'(top_bin[i]))
                begin
                    sorted_bins[j] = sorted_bins[j-1];
                    j--;
                end
                sorted_bins[j] = top_bin[i];
            end
            for (i = 0; i < m; i++)
            begin
                rep.bin = sorted_bins[i];
                rep.status = stpb_pkg::STATUS_OK;
                rep.is_last = (i + 1 == m);
                expected_reports.push_back(rep);
            end
        end
        win_older = '0;
        win_newer = '0;
        bin_count = '0;
        peaks_found = '0;
        table_fill = '0;
    endtask

    task automatic send_sample(input logic [stpb_pkg::DEF_SAMPLE_BITS-1:0] mag,
                               input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                sample_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        sample_valid <= 1'b1;
        magnitude    <= mag;
        last_sample  <= is_last;
        do @(posedge clk); while (!sample_ready);
        predict_sample(mag, is_last);
        items_sent++;
    endtask

    task automatic send_buffered_spectrum();
        for (int i = 0; i < spectrum_buf.size(); i++)
            send_sample(spectrum_buf[i], i == spectrum_buf.size() - 1);
        spectra_sent++;
    endtask

    task automatic build_random_spectrum();
        int len;
        int style;
        int pick;
        pick = $urandom_range(0, 19);
        len = (pick < 3) ? $urandom_range(1, 2) : (pick < 17) ? $urandom_range(3, 20)
                                                                 : $urandom_range(21, 48);
        style = $urandom_range(0, 3);
        spectrum_buf.delete();
        for (int i = 0; i < len; i++)
        begin
            case (style)
                0: spectrum_buf.push_back($urandom_range(0, 65535));
                1: spectrum_buf.push_back($urandom_range(0, 3));
                2: spectrum_buf.push_back((i % 2 == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(256, 65535));
                default:
                begin
                    pick = $urandom_range(0, 2);
                    spectrum_buf.push_back((pick == 0) ? 0 : (pick == 1) ? 65535
                                                       : $urandom_range(0, 65535));
                end
            endcase
        end
    endtask

    task automatic write_target(input logic [stpb_pkg::TARGET_W-1:0] value);
        @(negedge clk);
        sample_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        @(negedge clk);
        sample_valid <= 1'b0;
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= value;
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        target_reg = value;
        burst_left = 0;
    endtask

    task automatic test_directed_edges();
        spectrum_buf = '{65535};
        send_buffered_spectrum();
        spectrum_buf = '{0, 65535};
        send_buffered_spectrum();
        spectrum_buf = '{0, 65535, 0};
        send_buffered_spectrum();
        spectrum_buf = '{65535, 2, 5, 1, 9, 0, 65535};
        send_buffered_spectrum();
        spectrum_buf = '{0, 9, 0, 9, 1};
        send_buffered_spectrum();
        spectrum_buf = '{1, 4, 4, 1};
        send_buffered_spectrum();
    endtask

    task automatic test_random_spectra();
        int phase_targets[7];
        int start_items;
        int phase;
        phase_targets = '{16, 0, 31, 4, 1, 9, 2};
        start_items = items_sent;
        phase = 0;
        while (items_sent - start_items < 150)
        begin
            write_target((phase < 7) ? phase_targets[phase] : $urandom_range(0, 31));
            repeat ($urandom_range(3, 6))
            begin
                build_random_spectrum();
                send_buffered_spectrum();
            end
            phase++;
        end
    endtask

    task automatic test_backpressure();
        write_target(2);
        hold_request = 1'b1;
        repeat (16)
        begin
            spectrum_buf.delete();
            repeat ($urandom_range(3, 6))
                spectrum_buf.push_back($urandom_range(0, 65535));
            send_buffered_spectrum();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_reports.size() == 0)
                report_mismatch("unexpected result, bin", bin_index, -1);
            else
            begin
                oldest_report = expected_reports.pop_front();
                reports_checked++;
                if (bin_index !== oldest_report.bin)
                    report_mismatch("bin_index", bin_index, oldest_report.bin);
                if (status !== oldest_report.status)
                    report_mismatch("status", status, oldest_report.status);
                if (peak_count !== oldest_report.count)
                    report_mismatch("peak_count", peak_count, oldest_report.count);
                if (last_result !== oldest_report.is_last)
                    report_mismatch("last_result", last_result, oldest_report.is_last);
            end
        end
    end

    initial
    begin : result_sink
        int mode;
        int span;
        int hold_left;
        result_ready = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_request)
                begin
                    hold_request = 1'b0;
                    hold_left = 300;
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    result_ready <= 1'b0;
                end
                else
                begin
                    case (mode)
                        0: result_ready <= 1'b1;
                        1: result_ready <= $urandom_range(0, 1);
                        2: result_ready <= ($urandom_range(0, 3) == 0);
                        default: result_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        magnitude    = '0;
        last_sample  = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        hold_request = 1'b0;
        mismatches   = 0;
        items_sent   = 0;
        spectra_sent = 0;
        reports_checked = 0;
        burst_left   = 0;
        target_reg   = stpb_pkg::TARGET_RESET;
        win_older    = '0;
        win_newer    = '0;
        bin_count    = '0;
        peaks_found  = '0;
        table_fill   = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_random_spectra();
        test_backpressure();

        @(negedge clk);
        sample_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);

        $display("%0d spectra, %0d items, %0d results checked, %0d mismatches",
                 spectra_sent, items_sent, reports_checked, mismatches);
        $display("targets 0..31 incl. clamping, ties, plateaus, short spectra, long hold-off");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[spectrum_top_peak_bins.f]
src/stpb_pkg.sv
src/stpb_front.sv
src/stpb_queue.sv
src/stpb_back.sv
src/spectrum_top_peak_bins.sv
test/testbench.sv
